>>> rtl/gibs_pkg.sv
// ----------------------------------------------------------------------------
// gibs_pkg: shared types and constants
// Widths, cell entry layout, control bundle and sequencer states for the
// greedy IoU box suppression block.
// ----------------------------------------------------------------------------
package gibs_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int COORD_W   = 16;
  localparam int SCORE_W   = 16;
  localparam int AREA_W    = 2 * COORD_W;
  localparam int UNION_W   = AREA_W + 1;
  localparam int LIMIT_W   = 16;
  localparam int PROD_W    = LIMIT_W + UNION_W;

  localparam logic [LIMIT_W-1:0] IOU_LIMIT_RST = 16'd29491;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_IOU_LIMIT = 3'd0;

  // one stored box
  typedef struct packed {
    logic               vld;
    logic               supp;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic [SCORE_W-1:0] score;
    logic [AREA_W-1:0]  area;
  } ent_t;

  // chain control
  typedef struct packed {
    logic load;  // insert new box in score order
    logic pop;   // shift chain toward the head
    logic calc;  // register intersection against reference box
    logic mark;  // finish overlap test, set suppression
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_MARK
  } state_t;

  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi);
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

>>> rtl/gibs_if.sv
// ----------------------------------------------------------------------------
// gibs_if: stream channels
// Box input channel and kept index result channel, valid/ready.
// ----------------------------------------------------------------------------
interface gibs_box_if;
  logic                        valid;
  logic                        ready;
  logic [gibs_pkg::COORD_W-1:0] left_edge;
  logic [gibs_pkg::COORD_W-1:0] top_edge;
  logic [gibs_pkg::COORD_W-1:0] right_edge;
  logic [gibs_pkg::COORD_W-1:0] bottom_edge;
  logic [gibs_pkg::SCORE_W-1:0] box_score;
  logic                        final_box;

  modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                  box_score, final_box, input ready);
  modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                box_score, final_box, output ready);
endinterface

interface gibs_kept_if;
  logic                      valid;
  logic                      ready;
  logic [gibs_pkg::IDX_W-1:0] kept_index;
  logic                      final_kept;

  modport source (output valid, kept_index, final_kept, input ready);
  modport sink (input valid, kept_index, final_kept, output ready);
endinterface

>>> rtl/gibs_cell.sv
// ----------------------------------------------------------------------------
// gibs_cell: one slot of the box chain
// Holds one box, takes part in sorted insertion and in the overlap test.
// ----------------------------------------------------------------------------
module gibs_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gibs_pkg::ctrl_t               ctrl_i,
  input  gibs_pkg::ent_t                new_i,
  input  gibs_pkg::ent_t                prev_i,
  input  logic                          gt_prev_i,
  input  gibs_pkg::ent_t                next_i,
  input  gibs_pkg::ent_t                ref_i,
  input  logic [gibs_pkg::LIMIT_W-1:0]  limit_i,
  output gibs_pkg::ent_t                ent_o,
  output logic                          gt_o
);

  gibs_pkg::ent_t                 ent_r, ent_nxt;
  logic [gibs_pkg::AREA_W-1:0]    inter_r, inter_nxt;
  logic [gibs_pkg::COORD_W-1:0]   w, h;
  logic [gibs_pkg::UNION_W-1:0]   uni;
  logic [gibs_pkg::PROD_W-1:0]    lhs, rhs;
  logic                           over;

  // new box ranks ahead of this one (empty slot counts as lower)
  assign gt_o = !ent_r.vld || (new_i.score > ent_r.score);

  always_comb begin
    w = gibs_pkg::span((ref_i.x1 > ent_r.x1) ? ref_i.x1 : ent_r.x1,
                       (ref_i.x2 < ent_r.x2) ? ref_i.x2 : ent_r.x2);
    h = gibs_pkg::span((ref_i.y1 > ent_r.y1) ? ref_i.y1 : ent_r.y1,
                       (ref_i.y2 < ent_r.y2) ? ref_i.y2 : ent_r.y2);
    inter_nxt = inter_r;
    if (ctrl_i.calc) inter_nxt = w * h;
  end

  always_comb begin
    uni  = {1'b0, ref_i.area} + {1'b0, ent_r.area} - {1'b0, inter_r};
    lhs  = {{(gibs_pkg::PROD_W-gibs_pkg::AREA_W-16){1'b0}}, inter_r, 16'h0000};
    rhs  = limit_i * uni;
    over = lhs > rhs;
  end

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl_i.load) begin
      if (gt_o && gt_prev_i) ent_nxt = prev_i;
      else if (gt_o)         ent_nxt = new_i;
    end else if (ctrl_i.pop) begin
      ent_nxt = next_i;
    end else if (ctrl_i.mark) begin
      ent_nxt.supp = ent_r.supp | (ent_r.vld & over);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r <= '0;
    else        ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    inter_r <= inter_nxt;
  end

  assign ent_o = ent_r;

endmodule

>>> rtl/gibs_chain.sv
// ----------------------------------------------------------------------------
// gibs_chain: row of box cells
// Cell 0 is the head, holding the highest ranked box still pending.
// ----------------------------------------------------------------------------
module gibs_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gibs_pkg::ctrl_t               ctrl_i,
  input  gibs_pkg::ent_t                new_i,
  input  gibs_pkg::ent_t                ref_i,
  input  logic [gibs_pkg::LIMIT_W-1:0]  limit_i,
  output gibs_pkg::ent_t                head_o
);

  gibs_pkg::ent_t ent [gibs_pkg::MAX_BOXES];
  logic           gt  [gibs_pkg::MAX_BOXES];

  for (genvar i = 0; i < gibs_pkg::MAX_BOXES; i++) begin : g_cell
    gibs_pkg::ent_t prev_e, next_e;
    logic           gt_prev;

    if (i == 0) begin : g_first
      assign prev_e  = '0;
      assign gt_prev = 1'b0;
    end else begin : g_mid
      assign prev_e  = ent[i-1];
      assign gt_prev = gt[i-1];
    end

    if (i == gibs_pkg::MAX_BOXES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_notlast
      assign next_e = ent[i+1];
    end

    gibs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl_i),
      .new_i     (new_i),
      .prev_i    (prev_e),
      .gt_prev_i (gt_prev),
      .next_i    (next_e),
      .ref_i     (ref_i),
      .limit_i   (limit_i),
      .ent_o     (ent[i]),
      .gt_o      (gt[i])
    );
  end

  assign head_o = ent[0];

endmodule

>>> rtl/greedy_iou_box_suppression_top.sv
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression_top: greedy IoU non-maximum suppression
// Loads boxes into a score-sorted cell chain, then pops the chain, keeping
// each unsuppressed head box and testing it against all boxes behind it.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  in_box   in   valid/ready      left/top/right/bottom_edge, box_score, final_box
//  out_kept out  valid/ready      kept_index, final_kept
//  cfg_*    in   APB, pready = 1  reg 0 @ 0x0: iou_limit
//
//  Loading: one box per cycle; each box is inserted into score order as it
//  arrives. After the final box, the chain is popped at the head: a
//  suppressed box is only popped; a kept box is popped, intersected, then
//  compared and marked in every cell at once. Last, the set is closed.
//  No input is taken until the set closes. A stalled result holds the pop
//  only when a new kept box must push out the one before it, and holds the
//  close until the last kept index can go out.
//  Reset clears chain valid bits, counts and sets iou_limit to 29491.
//
module greedy_iou_box_suppression_top (
  input  logic        clk,
  input  logic        rst_n,
  gibs_box_if.sink    in_box,
  gibs_kept_if.source out_kept,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  gibs_pkg::state_t                state_r, state_nxt;
  logic [gibs_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [gibs_pkg::LIMIT_W-1:0]    limit_r;
  gibs_pkg::ent_t                  ref_r, ref_nxt;
  gibs_pkg::ent_t                  head, new_e;
  gibs_pkg::ctrl_t                 ctrl;
  logic                            pend_vld_r, pend_vld_nxt;
  logic [gibs_pkg::IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [gibs_pkg::IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_free, in_acc;
  logic [gibs_pkg::COORD_W-1:0]    sx, sy;

  // ---- configuration ----
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == gibs_pkg::ADDR_IOU_LIMIT) ? {16'h0000, limit_r}
                                                              : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= gibs_pkg::IOU_LIMIT_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == gibs_pkg::ADDR_IOU_LIMIT)
      limit_r <= cfg_pwdata[gibs_pkg::LIMIT_W-1:0];
  end

  // ---- incoming box ----
  assign in_box.ready = (state_r == gibs_pkg::ST_IDLE);
  assign in_acc       = in_box.valid && in_box.ready;

  always_comb begin
    sx          = gibs_pkg::span(in_box.left_edge, in_box.right_edge);
    sy          = gibs_pkg::span(in_box.top_edge, in_box.bottom_edge);
    new_e       = '0;
    new_e.vld   = 1'b1;
    new_e.idx   = count_r[gibs_pkg::IDX_W-1:0];
    new_e.x1    = in_box.left_edge;
    new_e.y1    = in_box.top_edge;
    new_e.x2    = in_box.right_edge;
    new_e.y2    = in_box.bottom_edge;
    new_e.score = in_box.box_score;
    new_e.area  = sx * sy;
  end

  gibs_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (ctrl),
    .new_i   (new_e),
    .ref_i   (ref_r),
    .limit_i (limit_r),
    .head_o  (head)
  );

  assign out_free = !out_vld_r || out_kept.ready;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gibs_pkg::ST_IDLE: if (in_acc && in_box.final_box) state_nxt = gibs_pkg::ST_SCAN;
      gibs_pkg::ST_SCAN: begin
        if (!head.vld) begin
          if (out_free) state_nxt = gibs_pkg::ST_IDLE;
        end else if (!head.supp && (!pend_vld_r || out_free)) begin
          state_nxt = gibs_pkg::ST_CALC;
        end
      end
      gibs_pkg::ST_CALC: state_nxt = gibs_pkg::ST_MARK;
      gibs_pkg::ST_MARK: state_nxt = gibs_pkg::ST_SCAN;
      default:           state_nxt = gibs_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs / datapath control ----
  always_comb begin
    ctrl         = '0;
    count_nxt    = count_r;
    ref_nxt      = ref_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    out_vld_nxt  = out_vld_r && !out_kept.ready;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      gibs_pkg::ST_IDLE: begin
        // boxes past capacity are dropped; final mark still counts
        if (in_acc && count_r < gibs_pkg::CNT_W'(gibs_pkg::MAX_BOXES)) begin
          ctrl.load = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      gibs_pkg::ST_SCAN: begin
        if (!head.vld) begin
          // set done: flush last kept index with its end mark
          if (out_free) begin
            out_vld_nxt  = 1'b1;
            out_idx_nxt  = pend_idx_r;
            out_last_nxt = 1'b1;
            pend_vld_nxt = 1'b0;
            count_nxt    = '0;
          end
        end else if (head.supp) begin
          ctrl.pop = 1'b1;
        end else if (!pend_vld_r || out_free) begin
          ctrl.pop     = 1'b1;
          ref_nxt      = head;
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = head.idx;
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_idx_nxt  = pend_idx_r;
            out_last_nxt = 1'b0;
          end
        end
      end
      gibs_pkg::ST_CALC: ctrl.calc = 1'b1;
      gibs_pkg::ST_MARK: ctrl.mark = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gibs_pkg::ST_IDLE;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r      <= ref_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_kept.valid      = out_vld_r;
  assign out_kept.kept_index = out_idx_r;
  assign out_kept.final_kept = out_last_r;

`ifndef NO_ASSERTIONS
  a_end_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gibs_pkg::ST_SCAN && !head.vld) |-> pend_vld_r)
    else $error("set ends with no kept box");
  a_calc_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gibs_pkg::ST_CALC) |=> (state_r == gibs_pkg::ST_MARK))
    else $error("overlap test sequence broken");
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gibs_pkg::ST_SCAN && state_nxt == gibs_pkg::ST_IDLE)
    |=> (out_vld_r && out_last_r && count_r == '0))
    else $error("set closed without end mark");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gibs_pkg::CNT_W'(gibs_pkg::MAX_BOXES))
    else $error("box count past capacity");
`endif

endmodule
